// ----- rtl/core/slotted_page_first_fit_store_macros.svh -----
// assertion helpers for the slotted page store
`ifndef SLOTTED_PAGE_FIRST_FIT_STORE_MACROS_SVH
`define SLOTTED_PAGE_FIRST_FIT_STORE_MACROS_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define SPFFS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SPFFS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/spffs_pkg.sv -----
package spffs_pkg;

	localparam int MAX_PAGES  = 32;
	localparam int MAX_SLOTS  = 64;

	localparam int PG_W       = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
	localparam int PG_CNT_W   = $clog2(MAX_PAGES + 1);
	localparam int SLOT_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int CNT_W      = $clog2(MAX_SLOTS + 1);
	localparam int USED_W     = 17;
	localparam int KEY_W      = 32;
	localparam int SIZE_W     = 16;
	localparam int META_DEPTH = 2 ** PG_W;
	localparam int KEY_DEPTH  = 2 ** (PG_W + SLOT_W);

	// fit test sum: used + size + slot entry + header + slot table
	localparam int NEED_W     = 19;
	localparam int HDR_BYTES  = 16;
	localparam int SLOT_BYTES = 4;

	localparam int PAGE_NUM_W = 6;
	localparam int SLOT_NUM_W = 7;

	localparam logic [SIZE_W-1:0] PAGE_SIZE_RST = 16'd4096;

	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_STATUS = 2'd1;
	localparam logic [1:0] KIND_SEARCH = 2'd2;

	localparam logic [1:0] RES_OK   = 2'd0;
	localparam logic [1:0] RES_MISS = 2'd1;
	localparam logic [1:0] RES_FULL = 2'd2;

	typedef struct packed {
		logic [1:0]              kind;
		logic [SIZE_W-1:0]       record_size;
		logic signed [KEY_W-1:0] key;
	} cmd_t;

	typedef struct packed {
		logic [1:0]            kind_echo;
		logic [1:0]            status;
		logic [PAGE_NUM_W-1:0] page_number;
		logic [SLOT_NUM_W-1:0] slot_number;
		logic                  last;
	} res_t;

	typedef struct packed {
		logic [USED_W-1:0] used;
		logic [CNT_W-1:0]  count;
	} meta_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INS_RD,
		ST_INS_CHK,
		ST_INS_NEW,
		ST_SRCH_RD,
		ST_SRCH_META,
		ST_SRCH_KEY,
		ST_STAT_RD,
		ST_STAT_ROW
	} state_t;

endpackage

// ----- rtl/core/spffs_ram.sv -----
module spffs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/core/slotted_page_first_fit_store.sv -----
// insert: pages tested in order from page 0, the first that fits takes the record (<= 32 tested)
// insert into a fresh page when none fits, or refused with every page taken
// search: per page a meta read, then one stored key per cycle and a compare, ends on a hit
// status: header in the cycle after the transaction, then one row per open page
// one transaction at a time, the rate set by the single read port of the key and meta memories
// reset: no pages open, page_size back to 4096, memories are not cleared (never read unset)
`include "slotted_page_first_fit_store_macros.svh"

module slotted_page_first_fit_store
	import spffs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// command transaction
	input  logic              start,
	output logic              busy,
	input  cmd_t              command,
	// page size register
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [SIZE_W-1:0] cfg_data,
	// result strobe, cannot be held off
	output logic              result_valid,
	output res_t              result
);

	localparam int META_W = $bits(meta_t);
	localparam int KA_W   = PG_W + SLOT_W;

	state_t state_q, state_d;

	logic [SIZE_W-1:0]   page_size_q;
	logic [PG_CNT_W-1:0] pages_open_q, pages_open_d;
	logic [PG_W-1:0]     pg_q, pg_d;
	logic [CNT_W-1:0]    sl_q, sl_d;
	logic [CNT_W-1:0]    cnt_q, cnt_d;
	logic [KEY_W-1:0]    key_q;
	logic [SIZE_W-1:0]   size_q;

	// key compare stage, in the cycle after the key read
	logic                pend_s1;
	logic [SLOT_W-1:0]   slot_s1;

	logic                res_vld_q;
	res_t                res_q;

	// memory ports
	logic              meta_we;
	logic [PG_W-1:0]   meta_waddr;
	meta_t             meta_wdata;
	logic [PG_W-1:0]   meta_raddr;
	logic [META_W-1:0] meta_rdata;
	meta_t             meta_rd;

	logic              key_we;
	logic [KA_W-1:0]   key_waddr;
	logic [KA_W-1:0]   key_raddr;
	logic [KEY_W-1:0]  key_rdata;
	logic              key_issue;

	logic              emit;
	res_t              emit_res;

	logic              accept;
	logic              pg_last;
	logic [NEED_W-1:0] need;
	logic              fits;
	logic              hit;

	// page meta: used bytes and record count, one word per page
	spffs_ram #(
		.WIDTH (META_W),
		.DEPTH (META_DEPTH)
	) u_meta_ram (
		.clk   (clk),
		.we    (meta_we),
		.waddr (meta_waddr),
		.wdata (meta_wdata),
		.raddr (meta_raddr),
		.rdata (meta_rdata)
	);

	// stored keys, addressed by page and slot
	spffs_ram #(
		.WIDTH (KEY_W),
		.DEPTH (KEY_DEPTH)
	) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (key_waddr),
		.wdata (key_q),
		.raddr (key_raddr),
		.rdata (key_rdata)
	);

	assign busy         = (state_q != ST_IDLE);
	assign cfg_ready    = !busy;
	assign accept       = start && !busy;
	assign result_valid = res_vld_q;
	assign result       = res_q;

	assign meta_rd = meta_t'(meta_rdata);
	assign pg_last = ((PG_CNT_W'(pg_q) + PG_CNT_W'(1)) == pages_open_q);

	// first-fit test on the page word just read
	assign need = NEED_W'(meta_rd.used) + NEED_W'(size_q)
		+ NEED_W'(SLOT_BYTES + HDR_BYTES)
		+ NEED_W'(meta_rd.count) * NEED_W'(SLOT_BYTES);
	assign fits = (meta_rd.count < CNT_W'(MAX_SLOTS)) && (need <= NEED_W'(page_size_q));

	assign hit = pend_s1 && (key_rdata == key_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			page_size_q  <= PAGE_SIZE_RST;
			pages_open_q <= '0;
			pg_q         <= '0;
			sl_q         <= '0;
			cnt_q        <= '0;
			pend_s1      <= 1'b0;
			res_vld_q    <= 1'b0;
		end else begin
			state_q      <= state_d;
			pages_open_q <= pages_open_d;
			pg_q         <= pg_d;
			sl_q         <= sl_d;
			cnt_q        <= cnt_d;
			pend_s1      <= key_issue;
			res_vld_q    <= emit;
			if (cfg_valid && cfg_ready) begin
				page_size_q <= cfg_data;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q  <= KEY_W'(command.key);
			size_q <= command.record_size;
		end
		slot_s1 <= sl_q[SLOT_W-1:0];
		if (emit) begin
			res_q <= emit_res;
		end
	end

	always_comb begin
		state_d      = state_q;
		pages_open_d = pages_open_q;
		pg_d         = pg_q;
		sl_d         = sl_q;
		cnt_d        = cnt_q;
		meta_we      = 1'b0;
		meta_waddr   = pg_q;
		meta_wdata   = '0;
		meta_raddr   = pg_q;
		key_we       = 1'b0;
		key_waddr    = {pg_q, meta_rd.count[SLOT_W-1:0]};
		key_raddr    = {pg_q, sl_q[SLOT_W-1:0]};
		key_issue    = 1'b0;
		emit         = 1'b0;
		emit_res     = '0;

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					pg_d = '0;
					unique case (command.kind)
						KIND_INSERT: begin
							state_d = (pages_open_q == '0) ? ST_INS_NEW : ST_INS_RD;
						end
						KIND_STATUS: begin
							// header carries the page count
							emit                 = 1'b1;
							emit_res.kind_echo   = KIND_STATUS;
							emit_res.status      = RES_OK;
							emit_res.page_number = PAGE_NUM_W'(pages_open_q);
							emit_res.last        = (pages_open_q == '0);
							if (pages_open_q != '0) begin
								state_d = ST_STAT_RD;
							end
						end
						KIND_SEARCH: begin
							if (pages_open_q == '0) begin
								emit               = 1'b1;
								emit_res.kind_echo = KIND_SEARCH;
								emit_res.status    = RES_MISS;
								emit_res.last      = 1'b1;
							end else begin
								state_d = ST_SRCH_RD;
							end
						end
						default: begin
							// unused kind: dropped without a result
						end
					endcase
				end
			end

			ST_INS_RD: begin
				state_d = ST_INS_CHK;
			end

			ST_INS_CHK: begin
				if (fits) begin
					// record goes into the next free slot of this page
					key_we               = 1'b1;
					meta_we              = 1'b1;
					meta_wdata.used      = meta_rd.used + USED_W'(size_q);
					meta_wdata.count     = meta_rd.count + CNT_W'(1);
					emit                 = 1'b1;
					emit_res.kind_echo   = KIND_INSERT;
					emit_res.status      = RES_OK;
					emit_res.page_number = PAGE_NUM_W'(pg_q);
					emit_res.slot_number = SLOT_NUM_W'(meta_rd.count);
					emit_res.last        = 1'b1;
					state_d              = ST_IDLE;
				end else if (pg_last) begin
					state_d = ST_INS_NEW;
				end else begin
					pg_d    = pg_q + PG_W'(1);
					state_d = ST_INS_RD;
				end
			end

			ST_INS_NEW: begin
				emit               = 1'b1;
				emit_res.kind_echo = KIND_INSERT;
				emit_res.last      = 1'b1;
				state_d            = ST_IDLE;
				if (pages_open_q >= PG_CNT_W'(MAX_PAGES)) begin
					emit_res.status = RES_FULL;
				end else begin
					// fresh page takes the record even when it is oversized
					key_we               = 1'b1;
					key_waddr            = {pages_open_q[PG_W-1:0], SLOT_W'(0)};
					meta_we              = 1'b1;
					meta_waddr           = pages_open_q[PG_W-1:0];
					meta_wdata.used      = USED_W'(size_q);
					meta_wdata.count     = CNT_W'(1);
					pages_open_d         = pages_open_q + PG_CNT_W'(1);
					emit_res.status      = RES_OK;
					emit_res.page_number = PAGE_NUM_W'(pages_open_q);
				end
			end

			ST_SRCH_RD: begin
				state_d = ST_SRCH_META;
			end

			ST_SRCH_META: begin
				sl_d  = '0;
				cnt_d = meta_rd.count;
				if (meta_rd.count != '0) begin
					state_d = ST_SRCH_KEY;
				end else if (pg_last) begin
					emit               = 1'b1;
					emit_res.kind_echo = KIND_SEARCH;
					emit_res.status    = RES_MISS;
					emit_res.last      = 1'b1;
					state_d            = ST_IDLE;
				end else begin
					pg_d    = pg_q + PG_W'(1);
					state_d = ST_SRCH_RD;
				end
			end

			ST_SRCH_KEY: begin
				// one key read per cycle, compared in the cycle after
				if (hit) begin
					emit                 = 1'b1;
					emit_res.kind_echo   = KIND_SEARCH;
					emit_res.status      = RES_OK;
					emit_res.page_number = PAGE_NUM_W'(pg_q);
					emit_res.slot_number = SLOT_NUM_W'(slot_s1);
					emit_res.last        = 1'b1;
					state_d              = ST_IDLE;
				end else if (sl_q != cnt_q) begin
					key_issue = 1'b1;
					sl_d      = sl_q + CNT_W'(1);
				end else if (pg_last) begin
					emit               = 1'b1;
					emit_res.kind_echo = KIND_SEARCH;
					emit_res.status    = RES_MISS;
					emit_res.last      = 1'b1;
					state_d            = ST_IDLE;
				end else begin
					pg_d    = pg_q + PG_W'(1);
					state_d = ST_SRCH_RD;
				end
			end

			ST_STAT_RD: begin
				state_d = ST_STAT_ROW;
			end

			ST_STAT_ROW: begin
				emit                 = 1'b1;
				emit_res.kind_echo   = KIND_STATUS;
				emit_res.status      = RES_OK;
				emit_res.page_number = PAGE_NUM_W'(pg_q);
				emit_res.slot_number = SLOT_NUM_W'(meta_rd.count);
				emit_res.last        = pg_last;
				if (pg_last) begin
					state_d = ST_IDLE;
				end else begin
					pg_d    = pg_q + PG_W'(1);
					state_d = ST_STAT_RD;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// page count never runs past the page store
	`SPFFS_ASSERT_NOW(a_pages_bounded, 1'b1, pages_open_q <= PG_CNT_W'(MAX_PAGES),
		"page count overflow")
	// only a status request gives more than one result
	`SPFFS_ASSERT_NOW(a_multi_only_status, result_valid && !result.last,
		result.kind_echo == KIND_STATUS, "non-final result outside status")
	// an accepted insert always sets busy
	`SPFFS_ASSERT_NXT(a_insert_busy, accept && command.kind == KIND_INSERT, busy,
		"insert did not hold busy")
	// no page free is reported only with every page open
	`SPFFS_ASSERT_NOW(a_full_when_exhausted, result_valid && result.status == RES_FULL,
		pages_open_q == PG_CNT_W'(MAX_PAGES), "full reported with pages left")
	// a search hit lies in an open page
	`SPFFS_ASSERT_NOW(a_hit_in_open_page,
		result_valid && result.kind_echo == KIND_SEARCH && result.status == RES_OK,
		result.page_number < PAGE_NUM_W'(pages_open_q), "search hit beyond open pages")

endmodule
